/* rtl/blt_pkg.sv */
// Shared types, register codes and helper functions of the blitter word datapath.
package blt_pkg;

   localparam int WORD_WIDTH      = 16;
   localparam int MINTERM_WIDTH   = 8;
   localparam int SHIFT_WIDTH     = 4;
   localparam int FILL_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 4;

   typedef logic [WORD_WIDTH-1:0]    word_type;
   typedef logic [SHIFT_WIDTH-1:0]   shift_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam word_type WORD_ONES = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_MINTERM          = 4'd0,
      REG_A_SHIFT          = 4'd1,
      REG_B_SHIFT          = 4'd2,
      REG_DESCENDING       = 4'd3,
      REG_FILL_MODE        = 4'd4,
      REG_FILL_CARRY_START = 4'd5,
      REG_FIRST_MASK       = 4'd6,
      REG_LAST_MASK        = 4'd7
   } reg_index_type;

   typedef enum logic [FILL_WIDTH-1:0] {
      FILL_NONE      = 2'd0,
      FILL_INCLUSIVE = 2'd1,
      FILL_EXCLUSIVE = 2'd2,
      FILL_BOTH      = 2'd3
   } fill_mode_type;

   typedef struct packed {
      logic [MINTERM_WIDTH-1:0] minterm;
      shift_type                a_shift;
      shift_type                b_shift;
      logic                     descending;
      fill_mode_type            fill_mode;
      logic                     fill_carry_start;
      word_type                 first_mask;
      word_type                 last_mask;
   } cfg_type;

   typedef struct packed {
      word_type a_word;
      word_type b_word;
      logic     b_fresh;
      word_type c_word;
      logic     row_first;
      logic     row_last;
      logic     blit_start;
   } req_type;

   typedef struct packed {
      word_type d_word;
      logic     all_zero;
      logic     carry_out;
   } rsp_type;

   // Barrel shift of the current word against the previous word of the same channel.
   function automatic word_type shift_word(word_type cur, word_type prev, shift_type sh,
                                           logic desc);
      logic [2*WORD_WIDTH-1:0] joined;
      logic [SHIFT_WIDTH:0]    amount;
      begin
         if (desc) begin
            joined = {cur, prev};
            amount = (SHIFT_WIDTH+1)'(WORD_WIDTH) - {1'b0, sh};
         end else begin
            joined = {prev, cur};
            amount = {1'b0, sh};
         end
         shift_word = word_type'(joined >> amount);
      end
   endfunction

   // Apply the 8-entry truth table bit by bit.
   function automatic word_type apply_minterm(logic [MINTERM_WIDTH-1:0] table_bits,
                                              word_type a, word_type b, word_type c);
      word_type d;
      begin
         for (int i = 0; i < WORD_WIDTH; i++) begin
            d[i] = table_bits[{a[i], b[i], c[i]}];
         end
         apply_minterm = d;
      end
   endfunction

endpackage

/* rtl/blt_if.sv */
// Channel interfaces: word request, word result and register write port.
interface blt_req_if;
   import blt_pkg::*;
   logic     valid;
   logic     ready;
   word_type a_word;
   word_type b_word;
   logic     b_fresh;
   word_type c_word;
   logic     row_first;
   logic     row_last;
   logic     blit_start;

   modport source (output valid, a_word, b_word, b_fresh, c_word, row_first, row_last,
                   blit_start, input ready);
   modport sink   (input valid, a_word, b_word, b_fresh, c_word, row_first, row_last,
                   blit_start, output ready);
endinterface

interface blt_rsp_if;
   import blt_pkg::*;
   logic     valid;
   logic     ready;
   word_type d_word;
   logic     all_zero;
   logic     carry_out;

   modport source (output valid, d_word, all_zero, carry_out, input ready);
   modport sink   (input valid, d_word, all_zero, carry_out, output ready);
endinterface

interface blt_csr_if;
   import blt_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   word_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/blt_csr.sv */
// Configuration register bank of the blitter word datapath.
module blt_csr (
   input  logic            clock,
   input  logic            reset,
   blt_csr_if.sink         csr_bus,
   output blt_pkg::cfg_type cfg
);
   import blt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_MINTERM:          cfg_in.minterm          = csr_bus.data[MINTERM_WIDTH-1:0];
            REG_A_SHIFT:          cfg_in.a_shift          = csr_bus.data[SHIFT_WIDTH-1:0];
            REG_B_SHIFT:          cfg_in.b_shift          = csr_bus.data[SHIFT_WIDTH-1:0];
            REG_DESCENDING:       cfg_in.descending       = csr_bus.data[0];
            REG_FILL_MODE:        cfg_in.fill_mode        =
                                     fill_mode_type'(csr_bus.data[FILL_WIDTH-1:0]);
            REG_FILL_CARRY_START: cfg_in.fill_carry_start = csr_bus.data[0];
            REG_FIRST_MASK:       cfg_in.first_mask       = csr_bus.data;
            REG_LAST_MASK:        cfg_in.last_mask        = csr_bus.data;
            default:              cfg_in = cfg_ff; // drop writes beyond the bank
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.minterm          <= '0;
         cfg_ff.a_shift          <= '0;
         cfg_ff.b_shift          <= '0;
         cfg_ff.descending       <= 1'b0;
         cfg_ff.fill_mode        <= FILL_NONE;
         cfg_ff.fill_carry_start <= 1'b0;
         cfg_ff.first_mask       <= WORD_ONES;
         cfg_ff.last_mask        <= WORD_ONES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/blt_core.sv */
// Word pipeline: input register, mask/shift/minterm/fill logic, result register.
module blt_core (
   input  logic             clock,
   input  logic             reset,
   input  blt_pkg::cfg_type cfg,
   blt_req_if.sink          req_bus,
   blt_rsp_if.source        rsp_bus
);
   import blt_pkg::*;

   // stage registers
   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff, in_data_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff, out_data_in;

   // blit state
   word_type prev_a_ff, prev_a_in;
   word_type prev_b_ff, prev_b_in;
   word_type b_hold_ff, b_hold_in;
   logic     carry_ff, carry_in;
   logic     zero_ff, zero_in;

   logic     advance;
   word_type a_masked;
   word_type prev_a_eff;
   word_type prev_b_eff;
   word_type a_shifted;
   word_type b_shifted;
   word_type raw_d;
   word_type fill_vec;
   word_type final_d;
   logic     carry_start;
   logic     carry_end;
   logic     fill_on;

   // result stage moves when it is empty or its word is taken
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.d_word    = out_data_ff.d_word;
   assign rsp_bus.all_zero  = out_data_ff.all_zero;
   assign rsp_bus.carry_out = out_data_ff.carry_out;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in          = 1'b1;
         in_data_in.a_word     = req_bus.a_word;
         in_data_in.b_word     = req_bus.b_word;
         in_data_in.b_fresh    = req_bus.b_fresh;
         in_data_in.c_word     = req_bus.c_word;
         in_data_in.row_first  = req_bus.row_first;
         in_data_in.row_last   = req_bus.row_last;
         in_data_in.blit_start = req_bus.blit_start;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      a_masked = in_data_ff.a_word
               & (in_data_ff.row_first ? cfg.first_mask : WORD_ONES)
               & (in_data_ff.row_last  ? cfg.last_mask  : WORD_ONES);
      prev_a_eff = in_data_ff.blit_start ? '0 : prev_a_ff;
      prev_b_eff = in_data_ff.blit_start ? '0 : prev_b_ff;

      a_shifted = shift_word(a_masked, prev_a_eff, cfg.a_shift, cfg.descending);
      b_shifted = in_data_ff.b_fresh
                ? shift_word(in_data_ff.b_word, prev_b_eff, cfg.b_shift, cfg.descending)
                : b_hold_ff;

      raw_d = apply_minterm(cfg.minterm, a_shifted, b_shifted, in_data_ff.c_word);

      carry_start = in_data_ff.row_first ? cfg.fill_carry_start : carry_ff;
      fill_on     = (cfg.fill_mode != FILL_NONE);

      // carry seen at each bit: start carry toggled by every set bit below it
      for (int i = 0; i < WORD_WIDTH; i++) begin
         fill_vec[i] = carry_start ^ (^(raw_d & ((WORD_WIDTH)'(1) << i) - (WORD_WIDTH)'(1)));
      end
      carry_end = carry_start ^ (^raw_d);

      case (cfg.fill_mode)
         FILL_NONE:      final_d = raw_d;
         FILL_INCLUSIVE: final_d = raw_d | fill_vec;
         default:        final_d = raw_d ^ fill_vec;
      endcase

      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      b_hold_in = b_hold_ff;
      carry_in  = carry_ff;
      zero_in   = zero_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      if (advance && in_valid_ff) begin
         prev_a_in = a_masked;
         if (in_data_ff.b_fresh) begin
            prev_b_in = in_data_ff.b_word;
            b_hold_in = b_shifted;
         end else begin
            prev_b_in = prev_b_eff;
         end
         carry_in = fill_on ? carry_end : carry_start;
         zero_in  = (in_data_ff.blit_start || zero_ff) && (final_d == '0);
         out_data_in.d_word    = final_d;
         out_data_in.all_zero  = zero_in;
         out_data_in.carry_out = carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         b_hold_ff    <= '0;
         carry_ff     <= 1'b0;
         zero_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prev_a_ff    <= prev_a_in;
         prev_b_ff    <= prev_b_in;
         b_hold_ff    <= b_hold_in;
         carry_ff     <= carry_in;
         zero_ff      <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

/* rtl/blitter_word_datapath.sv */
// Top level of the blitter word datapath: register bank and word pipeline.
//
// Usage:
//   req_bus carries one word set per transfer (A, B, C words, b_fresh, row_first,
//   row_last, blit_start). rsp_bus returns one D word per request with the sticky
//   all_zero flag and the fill carry after that word. csr_bus writes register
//   index/data pairs; it is always ready and must only be used while no request
//   is in flight. Out-of-range indexes are ignored.
//   A request accepted into the input register is passed to the result register
//   and so to rsp_bus when the result stage advances. Throughput: one word per
//   cycle while rsp_bus does not stall; the rate is set by the single pass of mask,
//   barrel shift, minterm and prefix fill between the input and result registers.
//   Reset clears both pipeline stages and the blit state (previous words, held
//   B, fill carry, zero flag set) and loads the register defaults, masks all ones.
//   When rsp_bus stalls the result register holds and the input register takes
//   one more word; req_bus.ready drops once both are full.
module blitter_word_datapath (
   input  logic     clock,
   input  logic     reset,
   blt_csr_if.sink  csr_bus,
   blt_req_if.sink  req_bus,
   blt_rsp_if.source rsp_bus
);
   import blt_pkg::*;

   cfg_type cfg;

   blt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   blt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
